@@ rtl/mwcm_pkg.sv @@
// Shared types and constants of the Microwire EEPROM command master.
`default_nettype none

package mwcm_pkg;

  // Field widths of the stream items and configuration registers
  localparam int FUNC_W    = 3;
  localparam int ADDR_W    = 7;
  localparam int WDATA_W   = 8;
  localparam int RDATA_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int PHASE_W   = 16;
  localparam int TIMEOUT_W = 20;
  localparam int CFG_IDX_W = 1;

  // Command codes carried in the func field
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ERASE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_EWEN  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_EWDS  = 3'd5;

  // Microwire opcodes
  localparam logic [1:0] OPC_READ  = 2'b10;
  localparam logic [1:0] OPC_WRITE = 2'b01;
  localparam logic [1:0] OPC_ERASE = 2'b11;
  localparam logic [1:0] OPC_EXT   = 2'b00;

  // Completion status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READY_TIMEOUT = 1'd1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ADDR_W-1:0]  address;
    logic [WDATA_W-1:0] write_data;
    logic               chip_sel;
    logic               rx_bit;
  } mwcm_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RDATA_W-1:0]  read_data;
    logic                done_res;
    logic                busy_res;
    logic [1:0]          cs_lines;
    logic                mosi;
    logic                sclk;
  } mwcm_res_t;

  typedef struct packed {
    logic [PHASE_W-1:0]   phase_ticks;
    logic [TIMEOUT_W-1:0] ready_timeout_ticks;
  } mwcm_cfg_t;

endpackage

`default_nettype wire

@@ rtl/mwcm_seq.sv @@
// Pin sequencer: command state, phase counters and the per-tick result.
`default_nettype none

module mwcm_seq import mwcm_pkg::*; #(
  parameter int ADDR_BITS = 7,
  parameter int DATA_BITS = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire mwcm_in_t  in_i,
  input  wire mwcm_cfg_t cfg_i,
  output mwcm_res_t      res_o
);

  localparam int SW  = ADDR_BITS + 3 + DATA_BITS;
  localparam int BLW = $clog2(SW + 1);
  localparam int IW  = $clog2(SW);
  localparam int CW  = ADDR_BITS + 3;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CS_SETUP, PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW, PH_RD_HIGH,
    PH_RD_LOW, PH_GAP, PH_RESEL, PH_POLL, PH_FINAL, PH_FINAL_TO
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [SW-1:0]        shift_out_q, shift_out_d;
  logic [BLW-1:0]       bits_left_q, bits_left_d, bl_dec;
  logic [DATA_BITS-1:0] shift_in_q, shift_in_d;
  logic [PHASE_W-1:0]   phase_cnt_q, phase_cnt_d, ph_lim, ph_inc;
  logic [TIMEOUT_W-1:0] ready_cnt_q, ready_cnt_d, rdy_lim, rdy_inc;
  logic                 sel_q, sel_d;
  logic [FUNC_W-1:0]    op_q, op_d;

  logic                 ph_over, is_cmd;
  logic [ADDR_BITS-1:0] addr_fld;
  logic [1:0]           opc;
  logic [CW-1:0]        cmd_word;

  // Next state and result of one tick
  always_comb begin
    phase_d     = phase_q;
    shift_out_d = shift_out_q;
    bits_left_d = bits_left_q;
    shift_in_d  = shift_in_q;
    phase_cnt_d = phase_cnt_q;
    ready_cnt_d = ready_cnt_q;
    sel_d       = sel_q;
    op_d        = op_q;
    res_o       = '0;

    // zero limits count as one
    ph_lim  = (cfg_i.phase_ticks == '0) ? PHASE_W'(1) : cfg_i.phase_ticks;
    ph_inc  = (phase_cnt_q < ph_lim) ? phase_cnt_q + PHASE_W'(1) : phase_cnt_q;
    ph_over = (ph_inc >= ph_lim);
    rdy_lim = (cfg_i.ready_timeout_ticks == '0) ? TIMEOUT_W'(1)
                                                : cfg_i.ready_timeout_ticks;
    rdy_inc = (ready_cnt_q < rdy_lim) ? ready_cnt_q + TIMEOUT_W'(1) : ready_cnt_q;
    bl_dec  = (bits_left_q != '0) ? bits_left_q - BLW'(1) : bits_left_q;

    is_cmd = (in_i.func >= FUNC_READ) && (in_i.func <= FUNC_EWDS);

    // command word: start bit, opcode, address field
    addr_fld = ADDR_BITS'(in_i.address);
    opc      = OPC_EXT;
    unique case (in_i.func)
      FUNC_READ:  opc = OPC_READ;
      FUNC_WRITE: opc = OPC_WRITE;
      FUNC_ERASE: opc = OPC_ERASE;
      FUNC_EWEN:  addr_fld = {2'b11, {(ADDR_BITS - 2){1'b0}}};
      default:    addr_fld = '0;
    endcase
    cmd_word = {1'b1, opc, addr_fld};

    if (phase_q == PH_IDLE) begin
      if (is_cmd) begin
        if (in_i.func == FUNC_WRITE) begin
          shift_out_d = {cmd_word, DATA_BITS'(in_i.write_data)};
          bits_left_d = BLW'(SW);
        end else begin
          shift_out_d = SW'(cmd_word);
          bits_left_d = BLW'(CW);
        end
        shift_in_d  = '0;
        ready_cnt_d = '0;
        sel_d       = in_i.chip_sel;
        op_d        = in_i.func;
        phase_d     = PH_CS_SETUP;
        phase_cnt_d = '0;
      end
    end else begin
      if (is_cmd) begin
        res_o.status = ST_REFUSED;
      end
      if (phase_q == PH_POLL) begin
        // one ready check per tick
        if (in_i.rx_bit) begin
          phase_d     = PH_FINAL;
          phase_cnt_d = '0;
        end else begin
          ready_cnt_d = rdy_inc;
          if (rdy_inc >= rdy_lim) begin
            phase_d     = PH_FINAL_TO;
            phase_cnt_d = '0;
          end
        end
      end else begin
        phase_cnt_d = ph_inc;
        if (ph_over) begin
          phase_cnt_d = '0;
          unique case (phase_q)
            PH_CS_SETUP:  phase_d = PH_BIT_SETUP;
            PH_BIT_SETUP: phase_d = PH_BIT_HIGH;
            PH_BIT_HIGH:  phase_d = PH_BIT_LOW;
            PH_BIT_LOW: begin
              bits_left_d = bl_dec;
              if (bl_dec != '0) begin
                phase_d = PH_BIT_SETUP;
              end else if (op_q == FUNC_READ) begin
                bits_left_d = BLW'(DATA_BITS);
                phase_d     = PH_RD_HIGH;
              end else if (op_q == FUNC_WRITE || op_q == FUNC_ERASE) begin
                phase_d = PH_GAP;
              end else begin
                phase_d = PH_FINAL;
              end
            end
            PH_RD_HIGH: phase_d = PH_RD_LOW;
            PH_RD_LOW: begin
              shift_in_d  = {shift_in_q[DATA_BITS-2:0], in_i.rx_bit};
              bits_left_d = bl_dec;
              phase_d     = (bl_dec != '0) ? PH_RD_HIGH : PH_FINAL;
            end
            PH_GAP: phase_d = PH_RESEL;
            PH_RESEL: begin
              ready_cnt_d = '0;
              phase_d     = PH_POLL;
            end
            PH_FINAL, PH_FINAL_TO: begin
              res_o.done_res = 1'b1;
              if (phase_q == PH_FINAL_TO) begin
                res_o.status = ST_TIMEOUT;
              end
              if (op_q == FUNC_READ) begin
                res_o.read_data = shift_in_q[RDATA_W-1:0];
              end
              phase_d = PH_IDLE;
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
    end

    // pin levels after this tick
    res_o.sclk     = (phase_d == PH_BIT_HIGH) || (phase_d == PH_RD_HIGH);
    res_o.busy_res = (phase_d != PH_IDLE);
    unique case (phase_d) inside
      PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW: begin
        if (bits_left_d != '0) begin
          res_o.mosi = shift_out_d[IW'(bits_left_d - BLW'(1))];
        end
      end
      default: res_o.mosi = 1'b0;
    endcase
    unique case (phase_d) inside
      PH_CS_SETUP, PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW, PH_RD_HIGH, PH_RD_LOW,
      PH_RESEL, PH_POLL: res_o.cs_lines = sel_d ? 2'b10 : 2'b01;
      default: res_o.cs_lines = 2'b00;
    endcase
  end

  // Sequencer state, advanced once per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      shift_out_q <= '0;
      bits_left_q <= '0;
      shift_in_q  <= '0;
      phase_cnt_q <= '0;
      ready_cnt_q <= '0;
      sel_q       <= 1'b0;
      op_q        <= FUNC_TICK;
    end else if (step_i) begin
      phase_q     <= phase_d;
      shift_out_q <= shift_out_d;
      bits_left_q <= bits_left_d;
      shift_in_q  <= shift_in_d;
      phase_cnt_q <= phase_cnt_d;
      ready_cnt_q <= ready_cnt_d;
      sel_q       <= sel_d;
      op_q        <= op_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mwcm_out_stage.sv @@
// Result register between the sequencer and the output stream.
`default_nettype none

module mwcm_out_stage import mwcm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire mwcm_res_t res_i,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output mwcm_res_t      res_o,
  output logic           in_ready_o
);

  logic      valid_q, valid_d;
  mwcm_res_t res_q;

  // take a new result whenever the held one is gone or leaves now
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ rtl/microwire_eeprom_command_master.sv @@
// Top level of the Microwire EEPROM command master.
`default_nettype none

// Microwire (93C46 style) EEPROM master stepped by tick items. Every input
// transfer is one tick: an idle block starts the command in func (read,
// write, erase, write enable, write disable) on the chosen chip select, and
// each later tick moves the pin sequence on by one step; commands sent while
// busy are ignored and answered with the refused status. Each input transfer
// gives exactly one result transfer holding the pin levels after that tick,
// plus done, read data and status on the tick a command ends. One item is
// taken every clock cycle; the result appears in the output register in the
// cycle after its transfer, and the rate is set only by back-pressure on the
// output stream. Pin phases last phase_ticks ticks; ready polling after a
// write or erase gives up after ready_timeout_ticks failed checks.
// User must write configuration only while no command runs; not enforced.

module microwire_eeprom_command_master import mwcm_pkg::*; #(
  parameter int ADDR_BITS = 7,
  parameter int DATA_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [TIMEOUT_W-1:0] cfg_wdata_i,
  // tick/command stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // address[6:0], write_data[14:7], chip_sel[15], rx_bit[16], zero[23:17]
  input  wire logic [23:0]          s_axis_tdata,
  // func[2:0]
  input  wire logic [FUNC_W-1:0]    s_axis_tuser,
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // sclk[0], mosi[1], cs_lines[3:2], busy_res[4], done_res[5],
  // read_data[13:6], status[15:14]
  output logic [15:0]               m_axis_tdata
);

  mwcm_cfg_t cfg_q;
  mwcm_in_t  in_item;
  mwcm_res_t seq_res, out_res;
  logic      step;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks         <= PHASE_W'(1);
      cfg_q.ready_timeout_ticks <= TIMEOUT_W'(10000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHASE_TICKS:   cfg_q.phase_ticks         <= cfg_wdata_i[PHASE_W-1:0];
        CFG_READY_TIMEOUT: cfg_q.ready_timeout_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Unpack the input item
  assign in_item.func       = s_axis_tuser;
  assign in_item.address    = s_axis_tdata[6:0];
  assign in_item.write_data = s_axis_tdata[14:7];
  assign in_item.chip_sel   = s_axis_tdata[15];
  assign in_item.rx_bit     = s_axis_tdata[16];

  assign step = s_axis_tvalid && s_axis_tready;

  mwcm_seq #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_item),
    .cfg_i  (cfg_q),
    .res_o  (seq_res)
  );

  mwcm_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (seq_res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .res_o       (out_res),
    .in_ready_o  (s_axis_tready)
  );

  assign m_axis_tdata = out_res;

endmodule

`default_nettype wire

@@ rtl/mwcm_checker.sv @@
// Port-level checks for the Microwire EEPROM command master, bound to the top.
`default_nettype none

module mwcm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // serial clock only toggles inside a running command
  a_sclk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[4])
    else $error("sclk high while not busy");

  // finishing tick leaves the bus released
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |-> !m_axis_tdata[4] && m_axis_tdata[3:2] == 2'b00)
    else $error("done with command still active");

  // never both chip selects at once
  a_cs_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:2] != 2'b11)
    else $error("both chip selects asserted");

  // read data only shows with done
  a_rdata_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[13:6] != 8'd0 |-> m_axis_tdata[5])
    else $error("read data without done");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind microwire_eeprom_command_master mwcm_checker u_mwcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
